### rtl/icsp_pkg.sv
package icsp_pkg;

    typedef struct packed {
        logic       req_type;
        logic [7:0] host_byte;
        logic       pin_bit;
    } t_in_item;

    typedef struct packed {
        logic [2:0] out_kind;
        logic       data_bit;
        logic [1:0] delay_ms;
        logic       pin_group;
        logic [2:0] pin_values;
        logic [7:0] reply_byte;
        logic       last;
    } t_out_item;

    typedef enum logic [2:0] {
        K_DRIVE   = 3'd0,
        K_RELEASE = 3'd1,
        K_SAMPLE  = 3'd2,
        K_DELAY   = 3'd3,
        K_PIN     = 3'd4,
        K_REPLY   = 3'd5,
        K_IDENT   = 3'd6,
        K_EXIT    = 3'd7
    } t_kind;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_HIGH = 2'd1,
        PH_LOW  = 2'd2,
        PH_READ = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        CLS_LOW   = 2'b00,
        CLS_CMD   = 2'b01,
        CLS_WRITE = 2'b10,
        CLS_READ  = 2'b11
    } t_cmd_class;

    typedef enum logic [3:0] {
        J_EXIT,
        J_IDENT,
        J_STATUS,
        J_PIN,
        J_CMD,
        J_CMD_WORD,
        J_CMD_READ,
        J_WORD,
        J_SAMPLE,
        J_READ_END
    } t_job;

    typedef struct packed {
        t_job        job;
        logic        four_bit;
        logic [1:0]  delay;
        logic [15:0] data;
    } t_desc;

    localparam logic [7:0] CMD_EXIT      = 8'h00;
    localparam logic [7:0] CMD_IDENT     = 8'h01;
    localparam logic [7:0] CMD_MODE_LO   = 8'h02;
    localparam logic [7:0] CMD_MODE_HI   = 8'h03;
    localparam logic [7:0] CMD_DELAY_LO  = 8'h04;
    localparam logic [7:0] CMD_DELAY_HI  = 8'h07;
    localparam logic [7:0] CMD_PIN_LO    = 8'h10;
    localparam logic [7:0] CMD_PIN_HI    = 8'h1F;

    localparam logic [1:0] DELAY_RESET   = 2'd2;
    localparam logic [4:0] CMD_BITS_4    = 5'd4;
    localparam logic [4:0] CMD_BITS_6    = 5'd6;
    localparam logic [4:0] READ_BITS_4   = 5'd16;
    localparam logic [4:0] READ_BITS_6   = 5'd14;
    localparam logic [4:0] WORD_STEPS    = 5'd16;
    localparam logic [4:0] WORD_TAIL_6   = 5'd15;
    localparam logic [7:0] STATUS_OK     = 8'd1;
    localparam logic [7:0] STATUS_FAIL   = 8'd0;

endpackage

### rtl/icsp_front.sv
module icsp_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  icsp_pkg::t_in_item i_req,
    output logic               o_job_valid,
    output icsp_pkg::t_desc    o_job
);
    import icsp_pkg::*;

    t_phase      r_phase, n_phase;
    logic        r_four, n_four;
    logic [1:0]  r_delay, n_delay;
    logic [7:0]  r_hold, n_hold;
    logic [15:0] r_shift, n_shift;
    logic [4:0]  r_bits, n_bits;
    logic [7:0]  b;

    assign b = i_req.host_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_four  <= 1'b0;
            r_delay <= DELAY_RESET;
            r_hold  <= '0;
            r_shift <= '0;
            r_bits  <= '0;
        end else begin
            r_phase <= n_phase;
            r_four  <= n_four;
            r_delay <= n_delay;
            r_hold  <= n_hold;
            r_shift <= n_shift;
            r_bits  <= n_bits;
        end
    end

    always_comb begin
        n_phase     = r_phase;
        n_four      = r_four;
        n_delay     = r_delay;
        n_hold      = r_hold;
        n_shift     = r_shift;
        n_bits      = r_bits;
        o_job_valid = 1'b0;
        o_job       = '{job: J_STATUS, four_bit: r_four, delay: r_delay, data: '0};
        if (i_accept) begin
            if (i_req.req_type) begin
                if (r_phase == PH_READ) begin
                    n_shift = {1'b0, r_shift[15:1]};
                    if (r_four) begin
                        n_shift[15] = i_req.pin_bit;
                    end else begin
                        n_shift[13] = r_shift[14] | i_req.pin_bit;
                    end
                    if (r_bits != '0) begin
                        n_bits = r_bits - 5'd1;
                    end
                    o_job_valid = 1'b1;
                    if (n_bits != '0) begin
                        o_job.job = J_SAMPLE;
                    end else begin
                        o_job.job  = J_READ_END;
                        o_job.data = n_shift;
                        n_phase    = PH_IDLE;
                    end
                end
            end else begin
                case (r_phase)
                    PH_READ: begin
                    end
                    PH_HIGH: begin
                        n_hold  = b;
                        n_phase = PH_LOW;
                    end
                    PH_LOW: begin
                        o_job_valid = 1'b1;
                        o_job.job   = J_WORD;
                        o_job.data  = {r_hold, b};
                        n_phase     = PH_IDLE;
                    end
                    default: begin
                        o_job_valid = 1'b1;
                        o_job.data  = {8'h00, b};
                        case (t_cmd_class'(b[7:6]))
                            CLS_LOW: begin
                                if (b == CMD_EXIT) begin
                                    o_job.job = J_EXIT;
                                    n_phase   = PH_IDLE;
                                    n_four    = 1'b0;
                                    n_delay   = DELAY_RESET;
                                    n_hold    = '0;
                                    n_shift   = '0;
                                    n_bits    = '0;
                                end else if (b == CMD_IDENT) begin
                                    o_job.job = J_IDENT;
                                end else if (b inside {[CMD_MODE_LO:CMD_MODE_HI]}) begin
                                    n_four     = b[0];
                                    o_job.data = {8'h00, STATUS_OK};
                                end else if (b inside {[CMD_DELAY_LO:CMD_DELAY_HI]}) begin
                                    n_delay    = b[1:0];
                                    o_job.data = {8'h00, STATUS_OK};
                                end else if (b inside {[CMD_PIN_LO:CMD_PIN_HI]}) begin
                                    o_job.job = J_PIN;
                                end else begin
                                    o_job.data = {8'h00, STATUS_FAIL};
                                end
                            end
                            CLS_CMD: begin
                                o_job.job = J_CMD;
                            end
                            CLS_WRITE: begin
                                o_job.job = J_CMD_WORD;
                                n_phase   = PH_HIGH;
                            end
                            default: begin
                                o_job.job = J_CMD_READ;
                                n_shift   = '0;
                                n_bits    = r_four ? READ_BITS_4 : READ_BITS_6;
                                n_phase   = PH_READ;
                            end
                        endcase
                    end
                endcase
            end
        end
    end

    a_read_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_READ) == (r_bits != '0))
        else $error("bit count out of step with the read phase");

    a_mode_held_in_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_READ) && $past(r_phase == PH_READ) |-> $stable(r_four))
        else $error("command mode changed during a read");

    a_no_job_on_pin_outside_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && i_req.req_type && (r_phase != PH_READ) |-> !o_job_valid)
        else $error("pin bit outside a read produced work");

endmodule

### rtl/icsp_queue.sv
module icsp_queue #(
    parameter int DEPTH = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  icsp_pkg::t_desc i_desc,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output icsp_pkg::t_desc o_desc
);
    import icsp_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_desc            r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == PTR_LAST) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == PTR_LAST) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    assign o_full  = (r_cnt == CNT_FULL);
    assign o_valid = (r_cnt != '0);
    assign o_desc  = r_mem[r_rd];

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_FULL)
        else $error("queue count beyond depth");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_cnt != '0)
        else $error("queue popped while empty");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> r_cnt != CNT_FULL)
        else $error("queue pushed while full");

endmodule

### rtl/icsp_back.sv
module icsp_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_job_valid,
    input  icsp_pkg::t_desc     i_job,
    output logic                o_job_pop,
    output logic                o_out_valid,
    output icsp_pkg::t_out_item o_out,
    input  logic                i_out_pop
);
    import icsp_pkg::*;

    logic      r_busy, n_busy;
    t_desc     r_desc;
    logic [4:0] r_step, n_step;
    logic      r_out_valid, n_out_valid;
    t_out_item r_out;
    t_out_item item;
    logic      out_free;
    logic      load;
    logic [4:0] ncmd;
    logic [4:0] rel;
    logic [4:0] word_idx;

    assign out_free = !r_out_valid || i_out_pop;
    assign ncmd     = r_desc.four_bit ? CMD_BITS_4 : CMD_BITS_6;
    assign rel      = r_step - ncmd - 5'd1;
    assign word_idx = r_step - 5'd1;

    always_comb begin
        item = '0;
        case (r_desc.job)
            J_EXIT: begin
                item.out_kind = K_EXIT;
                item.last     = 1'b1;
            end
            J_IDENT, J_PIN: begin
                if (r_step == '0) begin
                    item.out_kind   = (r_desc.job == J_IDENT) ? K_IDENT : K_PIN;
                    item.pin_group  = (r_desc.job == J_PIN) ? r_desc.data[3] : 1'b0;
                    item.pin_values = (r_desc.job == J_PIN) ? r_desc.data[2:0] : 3'd0;
                end else begin
                    item.out_kind   = K_REPLY;
                    item.reply_byte = STATUS_OK;
                    item.last       = 1'b1;
                end
            end
            J_STATUS: begin
                item.out_kind   = K_REPLY;
                item.reply_byte = r_desc.data[7:0];
                item.last       = 1'b1;
            end
            J_CMD, J_CMD_WORD, J_CMD_READ: begin
                if (r_step < ncmd) begin
                    item.out_kind = K_DRIVE;
                    item.data_bit = r_desc.data[r_step[3:0]];
                end else if (r_step == ncmd) begin
                    item.out_kind = K_DELAY;
                    item.delay_ms = r_desc.delay;
                    item.last     = (r_desc.job == J_CMD_WORD);
                end else if (rel == '0) begin
                    item.out_kind   = K_REPLY;
                    item.reply_byte = STATUS_OK;
                    item.last       = (r_desc.job == J_CMD);
                end else if (rel == 5'd1 && !r_desc.four_bit) begin
                    item.out_kind = K_RELEASE;
                end else begin
                    item.out_kind = K_SAMPLE;
                    item.last     = 1'b1;
                end
            end
            J_WORD: begin
                if (r_step == WORD_STEPS) begin
                    item.out_kind   = K_REPLY;
                    item.reply_byte = STATUS_OK;
                    item.last       = 1'b1;
                end else begin
                    item.out_kind = K_DRIVE;
                    if (r_desc.four_bit) begin
                        item.data_bit = r_desc.data[r_step[3:0]];
                    end else if (r_step == '0 || r_step == WORD_TAIL_6) begin
                        item.data_bit = 1'b0;
                    end else begin
                        item.data_bit = r_desc.data[word_idx[3:0]];
                    end
                end
            end
            J_SAMPLE: begin
                item.out_kind = K_SAMPLE;
                item.last     = 1'b1;
            end
            J_READ_END: begin
                if (r_step == '0) begin
                    item.out_kind = K_RELEASE;
                end else if (r_step == 5'd1) begin
                    item.out_kind   = K_REPLY;
                    item.reply_byte = r_desc.data[15:8];
                end else begin
                    item.out_kind   = K_REPLY;
                    item.reply_byte = r_desc.data[7:0];
                    item.last       = 1'b1;
                end
            end
            default: begin
                item.out_kind = K_EXIT;
                item.last     = 1'b1;
            end
        endcase
    end

    assign load      = i_job_valid && (!r_busy || (out_free && item.last));
    assign o_job_pop = load;

    always_comb begin
        n_busy      = r_busy;
        n_step      = r_step;
        n_out_valid = r_out_valid && !i_out_pop;
        if (r_busy && out_free) begin
            n_out_valid = 1'b1;
            n_step      = r_step + 5'd1;
            if (item.last) begin
                n_busy = 1'b0;
            end
        end
        if (load) begin
            n_busy = 1'b1;
            n_step = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_desc <= i_job;
        end
        if (r_busy && out_free) begin
            r_out <= item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_step <= WORD_STEPS)
        else $error("sequencer step beyond the longest job");

    a_held_when_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && !out_free |=> r_busy && $stable(r_step))
        else $error("sequencer advanced while the output was stalled");

    a_load_only_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load && r_busy |-> out_free && item.last)
        else $error("new job loaded before the current one finished");

endmodule

### rtl/icsp_command_serializer_unit.sv
// Channel   Handshake          Payload
// input     push / full        i_req (t_in_item)
// result    empty / pop        o_res (t_out_item)
//
// The front end takes one item per cycle while the job queue has room.
// The back end emits one result per cycle while the result is not stalled, 0 to 17 per item, which sets the rate.
// With the back end idle, an item's first result passes the job queue, the job register and the result register.
// Reset is synchronous; it restores phase, mode and delay and empties the queue.
// A stalled result holds the sequencer; input stops only when the queue fills.
module icsp_command_serializer_unit #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  icsp_pkg::t_in_item  i_req,
    output logic                empty,
    input  logic                pop,
    output icsp_pkg::t_out_item o_res
);
    import icsp_pkg::*;

    logic  accept;
    logic  job_valid;
    t_desc job;
    logic  q_valid;
    t_desc q_desc;
    logic  q_pop;
    logic  out_valid;

    assign accept = push && !full;

    icsp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_req       (i_req),
        .o_job_valid (job_valid),
        .o_job       (job)
    );

    icsp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_valid),
        .i_desc  (job),
        .o_full  (full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_desc  (q_desc)
    );

    icsp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (q_valid),
        .i_job       (q_desc),
        .o_job_pop   (q_pop),
        .o_out_valid (out_valid),
        .o_out       (o_res),
        .i_out_pop   (pop)
    );

    assign empty = !out_valid;

endmodule
